// ----- hw/rtl/spgm_pkg.sv -----
// ----------------------------------------------------------------------------
// spgm_pkg: shared types and constants of the stereo pan gain mixer
// Word layouts, register indexes, fixed-point widths and the cosine series
// divisors used to build the pan ROM.
// ----------------------------------------------------------------------------
package spgm_pkg;

    localparam int NUM_SOURCES   = 4;
    localparam int SAMPLE_BITS   = 16;
    localparam int SRC_IDX_BITS  = $clog2(NUM_SOURCES);

    // Source register: gain Q2.14 in the upper half, signed pan Q1.14 below
    localparam int GAIN_PAN_BITS = 32;
    localparam int GAIN_BITS     = 16;
    localparam int PAN_BITS      = 16;
    localparam int GAIN_FRAC     = 14;
    localparam int MASTER_BITS   = 16;
    localparam int MASTER_FRAC   = 12;

    // Pan ROM entries are Q1.14, 0 .. 16384
    localparam int ROM_BITS      = 15;
    localparam int ROM_ONE       = 16384;

    // Sample times effective gain, summed over sources
    localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS;
    localparam int SUM_BITS      = PROD_BITS + $clog2(NUM_SOURCES) + 1;

    // Configuration port
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASTER_GAIN = CFG_INDEX_BITS'(NUM_SOURCES);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO_MASK = CFG_INDEX_BITS'(NUM_SOURCES + 1);

    localparam logic [GAIN_PAN_BITS-1:0] GAIN_PAN_RESET    = 32'h4000_0000;
    localparam logic [MASTER_BITS-1:0]   MASTER_GAIN_RESET = 16'd4096;
    localparam logic [NUM_SOURCES-1:0]   STEREO_MASK_RESET = '1;

    // pi in Q2.30 and the Taylor divisors (2n-1)*2n of the cosine series
    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam int          SERIES_TERMS  = 10;
    localparam logic [8:0]  SERIES_DIV [1:SERIES_TERMS] =
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] src0_left;
        logic signed [SAMPLE_BITS-1:0] src0_right;
        logic signed [SAMPLE_BITS-1:0] src1_left;
        logic signed [SAMPLE_BITS-1:0] src1_right;
        logic signed [SAMPLE_BITS-1:0] src2_left;
        logic signed [SAMPLE_BITS-1:0] src2_right;
        logic signed [SAMPLE_BITS-1:0] src3_left;
        logic signed [SAMPLE_BITS-1:0] src3_right;
        logic [NUM_SOURCES-1:0]        present_mask;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix_left;
        logic signed [SAMPLE_BITS-1:0] mix_right;
        logic                          clipped;
        logic [NUM_SOURCES-1:0]        underrun_mask;
    } out_word_t;

    typedef struct packed {
        logic stereo;
        logic present;
    } lane_ctl_t;

endpackage

// ----- hw/rtl/spgm_lane.sv -----
// ----------------------------------------------------------------------------
// spgm_lane: one source lane of the mixer
// Clamps the pan, looks up the constant-power cosine gains, forms the
// effective gains and multiplies them into the samples. Four register stages.
// ----------------------------------------------------------------------------
module spgm_lane #(
    parameter int PAN_TABLE_DEPTH = 256
) (
    input  logic                                    clk,
    input  logic signed [spgm_pkg::SAMPLE_BITS-1:0] left,
    input  logic signed [spgm_pkg::SAMPLE_BITS-1:0] right,
    input  logic [spgm_pkg::GAIN_PAN_BITS-1:0]      gain_pan,
    input  spgm_pkg::lane_ctl_t                     ctl,
    output logic signed [spgm_pkg::PROD_BITS-1:0]   prod_l,
    output logic signed [spgm_pkg::PROD_BITS-1:0]   prod_r
);

    localparam int IDX_BITS    = $clog2(PAN_TABLE_DEPTH + 1);
    localparam int SCALED_BITS = 16 + IDX_BITS;
    localparam int ROM_DIV     = 2 * PAN_TABLE_DEPTH;
    localparam int EFF_BITS    = spgm_pkg::ROM_BITS + spgm_pkg::GAIN_BITS + 1;
    localparam int FULL_BITS   = spgm_pkg::SAMPLE_BITS + spgm_pkg::GAIN_BITS + 1;

    typedef logic [spgm_pkg::ROM_BITS-1:0] rom_arr_t [0:PAN_TABLE_DEPTH];

    // Quarter cosine, entry k = round(16384 * cos(k * pi / (2 * depth)))
    function automatic rom_arr_t build_rom();
        rom_arr_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        logic [63:0] r;
        for (int k = 0; k <= PAN_TABLE_DEPTH; k++) begin
            x    = (64'(k) * spgm_pkg::PI_Q30 + 64'(PAN_TABLE_DEPTH)) / ROM_DIV;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = 64'd1 << 30;
            acc  = longint'(term);
            for (int n = 1; n <= spgm_pkg::SERIES_TERMS; n++) begin
                term = ((term * x2) >> 30) / spgm_pkg::SERIES_DIV[n];
                if ((n % 2) == 1) acc = acc - longint'(term);
                else              acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            r = (64'(acc) + (64'd1 << 15)) >> 16;
            if (r > 64'(spgm_pkg::ROM_ONE)) r = 64'(spgm_pkg::ROM_ONE);
            rom[k] = r[spgm_pkg::ROM_BITS-1:0];
        end
        return rom;
    endfunction

    localparam rom_arr_t PAN_ROM = build_rom();

    // Stage 1: clamp pan, scale to table indices
    localparam int PAN_BITS_EXT = spgm_pkg::PAN_BITS + 1;
    logic signed [PAN_BITS_EXT-1:0] pan_raw;
    logic signed [PAN_BITS_EXT-1:0] pan_c;
    logic [PAN_BITS_EXT-1:0]        off_l;
    logic [PAN_BITS_EXT-1:0]        off_r;
    logic [SCALED_BITS-1:0]         scaled_l;
    logic [SCALED_BITS-1:0]         scaled_r;

    always_comb
    begin
        pan_raw = PAN_BITS_EXT'($signed(gain_pan[spgm_pkg::PAN_BITS-1:0]));
        if (pan_raw > PAN_BITS_EXT'(spgm_pkg::ROM_ONE))
            pan_c = PAN_BITS_EXT'(spgm_pkg::ROM_ONE);
        else if (pan_raw < -PAN_BITS_EXT'(spgm_pkg::ROM_ONE))
            pan_c = -PAN_BITS_EXT'(spgm_pkg::ROM_ONE);
        else
            pan_c = pan_raw;
        off_l    = PAN_BITS_EXT'(pan_c + PAN_BITS_EXT'(spgm_pkg::ROM_ONE));
        off_r    = PAN_BITS_EXT'(PAN_BITS_EXT'(spgm_pkg::ROM_ONE) - pan_c);
        scaled_l = SCALED_BITS'(off_l[15:0]) * SCALED_BITS'(PAN_TABLE_DEPTH)
                 + SCALED_BITS'(spgm_pkg::ROM_ONE);
        scaled_r = SCALED_BITS'(off_r[15:0]) * SCALED_BITS'(PAN_TABLE_DEPTH)
                 + SCALED_BITS'(spgm_pkg::ROM_ONE);
    end

    logic [IDX_BITS-1:0]                    idx_l_reg;
    logic [IDX_BITS-1:0]                    idx_r_reg;
    logic [spgm_pkg::GAIN_BITS-1:0]         gain1_reg;
    spgm_pkg::lane_ctl_t                    ctl1_reg;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] l1_reg;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] r1_reg;

    always_ff @(posedge clk)
    begin
        idx_l_reg <= scaled_l[15 +: IDX_BITS];
        idx_r_reg <= scaled_r[15 +: IDX_BITS];
        gain1_reg <= gain_pan[spgm_pkg::GAIN_PAN_BITS-1 -: spgm_pkg::GAIN_BITS];
        ctl1_reg  <= ctl;
        l1_reg    <= left;
        r1_reg    <= right;
    end

    // Stage 2: ROM lookup
    logic [spgm_pkg::ROM_BITS-1:0]           rom_l_reg;
    logic [spgm_pkg::ROM_BITS-1:0]           rom_r_reg;
    logic [spgm_pkg::GAIN_BITS-1:0]          gain2_reg;
    spgm_pkg::lane_ctl_t                     ctl2_reg;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] l2_reg;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] r2_reg;

    always_ff @(posedge clk)
    begin
        rom_l_reg <= PAN_ROM[idx_l_reg];
        rom_r_reg <= PAN_ROM[idx_r_reg];
        gain2_reg <= gain1_reg;
        ctl2_reg  <= ctl1_reg;
        l2_reg    <= l1_reg;
        r2_reg    <= r1_reg;
    end

    // Stage 3: effective gains; mono uses the plain gain, missing gets zero
    logic [EFF_BITS-1:0]            eff_l;
    logic [EFF_BITS-1:0]            eff_r;
    logic [spgm_pkg::GAIN_BITS-1:0] gl_next;
    logic [spgm_pkg::GAIN_BITS-1:0] gr_next;

    always_comb
    begin
        eff_l = EFF_BITS'(rom_l_reg) * EFF_BITS'(gain2_reg)
              + EFF_BITS'(1 << (spgm_pkg::GAIN_FRAC - 1));
        eff_r = EFF_BITS'(rom_r_reg) * EFF_BITS'(gain2_reg)
              + EFF_BITS'(1 << (spgm_pkg::GAIN_FRAC - 1));
        if (!ctl2_reg.present)
        begin
            gl_next = '0;
            gr_next = '0;
        end
        else if (ctl2_reg.stereo)
        begin
            gl_next = eff_l[spgm_pkg::GAIN_FRAC +: spgm_pkg::GAIN_BITS];
            gr_next = eff_r[spgm_pkg::GAIN_FRAC +: spgm_pkg::GAIN_BITS];
        end
        else
        begin
            gl_next = gain2_reg;
            gr_next = gain2_reg;
        end
    end

    logic [spgm_pkg::GAIN_BITS-1:0]          gl_reg;
    logic [spgm_pkg::GAIN_BITS-1:0]          gr_reg;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] sl_reg;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] sr_reg;

    always_ff @(posedge clk)
    begin
        gl_reg <= gl_next;
        gr_reg <= gr_next;
        sl_reg <= l2_reg;
        sr_reg <= ctl2_reg.stereo ? r2_reg : l2_reg;
    end

    // Stage 4: sample times gain
    logic signed [FULL_BITS-1:0] full_l;
    logic signed [FULL_BITS-1:0] full_r;

    always_comb
    begin
        full_l = sl_reg * $signed({1'b0, gl_reg});
        full_r = sr_reg * $signed({1'b0, gr_reg});
    end

    always_ff @(posedge clk)
    begin
        prod_l <= full_l[spgm_pkg::PROD_BITS-1:0];
        prod_r <= full_r[spgm_pkg::PROD_BITS-1:0];
    end

endmodule

// ----- hw/rtl/spgm_merge.sv -----
// ----------------------------------------------------------------------------
// spgm_merge: combine the lanes and apply the master gain
// Sums the lane products, scales by master gain in two partial products,
// rounds and saturates. Three register stages.
// ----------------------------------------------------------------------------
module spgm_merge (
    input  logic                                    clk,
    input  logic signed [spgm_pkg::PROD_BITS-1:0]   prod_l [spgm_pkg::NUM_SOURCES],
    input  logic signed [spgm_pkg::PROD_BITS-1:0]   prod_r [spgm_pkg::NUM_SOURCES],
    input  logic [spgm_pkg::MASTER_BITS-1:0]        master_gain,
    output logic signed [spgm_pkg::SAMPLE_BITS-1:0] mix_left,
    output logic signed [spgm_pkg::SAMPLE_BITS-1:0] mix_right,
    output logic                                    clipped
);

    localparam int HALF_BITS  = spgm_pkg::MASTER_BITS / 2;
    localparam int PART_BITS  = spgm_pkg::SUM_BITS + HALF_BITS + 1;
    localparam int V_BITS     = spgm_pkg::SUM_BITS + spgm_pkg::MASTER_BITS + 1;
    localparam int SHIFT      = spgm_pkg::GAIN_FRAC + spgm_pkg::MASTER_FRAC;
    localparam int Q_BITS     = V_BITS - SHIFT;
    localparam logic signed [Q_BITS-1:0] SAT_MAX = Q_BITS'((1 << (spgm_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0] SAT_MIN = -Q_BITS'(1 << (spgm_pkg::SAMPLE_BITS - 1));

    // Stage 1: sum the lanes
    logic signed [spgm_pkg::SUM_BITS-1:0] acc_l;
    logic signed [spgm_pkg::SUM_BITS-1:0] acc_r;
    logic signed [spgm_pkg::SUM_BITS-1:0] sum_l_reg;
    logic signed [spgm_pkg::SUM_BITS-1:0] sum_r_reg;

    always_comb
    begin
        acc_l = '0;
        acc_r = '0;
        for (int s = 0; s < spgm_pkg::NUM_SOURCES; s++)
        begin
            acc_l = acc_l + spgm_pkg::SUM_BITS'(prod_l[s]);
            acc_r = acc_r + spgm_pkg::SUM_BITS'(prod_r[s]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_l_reg <= acc_l;
        sum_r_reg <= acc_r;
    end

    // Stage 2: master gain split into upper and lower bytes
    logic signed [PART_BITS-1:0] hi_l_reg;
    logic signed [PART_BITS-1:0] lo_l_reg;
    logic signed [PART_BITS-1:0] hi_r_reg;
    logic signed [PART_BITS-1:0] lo_r_reg;
    logic signed [HALF_BITS:0]   mg_hi;
    logic signed [HALF_BITS:0]   mg_lo;

    always_comb
    begin
        mg_hi = $signed({1'b0, master_gain[spgm_pkg::MASTER_BITS-1 -: HALF_BITS]});
        mg_lo = $signed({1'b0, master_gain[HALF_BITS-1:0]});
    end

    always_ff @(posedge clk)
    begin
        hi_l_reg <= PART_BITS'(sum_l_reg) * PART_BITS'(mg_hi);
        lo_l_reg <= PART_BITS'(sum_l_reg) * PART_BITS'(mg_lo);
        hi_r_reg <= PART_BITS'(sum_r_reg) * PART_BITS'(mg_hi);
        lo_r_reg <= PART_BITS'(sum_r_reg) * PART_BITS'(mg_lo);
    end

    // Stage 3: recombine, round half up, saturate
    logic signed [V_BITS-1:0] v_l;
    logic signed [V_BITS-1:0] v_r;
    logic signed [Q_BITS-1:0] q_l;
    logic signed [Q_BITS-1:0] q_r;
    logic                     clip_l;
    logic                     clip_r;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] sat_l;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] sat_r;

    always_comb
    begin
        v_l = (V_BITS'(hi_l_reg) <<< HALF_BITS) + V_BITS'(lo_l_reg)
            + V_BITS'(64'd1 << (SHIFT - 1));
        v_r = (V_BITS'(hi_r_reg) <<< HALF_BITS) + V_BITS'(lo_r_reg)
            + V_BITS'(64'd1 << (SHIFT - 1));
        q_l = v_l[V_BITS-1:SHIFT];
        q_r = v_r[V_BITS-1:SHIFT];
        clip_l = (q_l > SAT_MAX) || (q_l < SAT_MIN);
        clip_r = (q_r > SAT_MAX) || (q_r < SAT_MIN);
        if (q_l > SAT_MAX)      sat_l = SAT_MAX[spgm_pkg::SAMPLE_BITS-1:0];
        else if (q_l < SAT_MIN) sat_l = SAT_MIN[spgm_pkg::SAMPLE_BITS-1:0];
        else                    sat_l = q_l[spgm_pkg::SAMPLE_BITS-1:0];
        if (q_r > SAT_MAX)      sat_r = SAT_MAX[spgm_pkg::SAMPLE_BITS-1:0];
        else if (q_r < SAT_MIN) sat_r = SAT_MIN[spgm_pkg::SAMPLE_BITS-1:0];
        else                    sat_r = q_r[spgm_pkg::SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        mix_left  <= sat_l;
        mix_right <= sat_r;
        clipped   <= clip_l | clip_r;
    end

endmodule

// ----- hw/rtl/stereo_pan_gain_mixer.sv -----
// ----------------------------------------------------------------------------
// stereo_pan_gain_mixer: four-source constant-power pan stereo mixer
// One frame in, one mixed and saturated stereo frame out, fully pipelined.
// ----------------------------------------------------------------------------
// The mixer takes one frame on every clock where start is high; busy never
// rises, so frames may follow each other in every cycle. Each frame comes
// back on result after the lane and merge stages below, marked by a one-cycle
// done strobe, in the order of arrival. The receiver cannot stall the
// result, so take it in the cycle done is high. A frame passes the four
// stages of each source lane (pan index, cosine ROM, effective gain, sample
// multiply) and then three in the merge (lane sum, master gain partial products,
// round and saturate). The cosine ROM has PAN_TABLE_DEPTH+1 entries, is
// built at elaboration and needs no fill after reset. Configuration writes
// are always taken (cfg_ready stays high); change registers only while no
// frame is in flight. Unknown register indexes are dropped.
// ----------------------------------------------------------------------------
module stereo_pan_gain_mixer #(
    parameter int PAN_TABLE_DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  spgm_pkg::in_word_t                       frame,
    output logic                                     done,
    output spgm_pkg::out_word_t                      result,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [spgm_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [spgm_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    localparam int LANE_STAGES  = 4;
    localparam int MERGE_STAGES = 3;
    localparam int LATENCY      = LANE_STAGES + MERGE_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [spgm_pkg::GAIN_PAN_BITS-1:0] gain_pan_reg [spgm_pkg::NUM_SOURCES];
    logic [spgm_pkg::MASTER_BITS-1:0]   master_gain_reg;
    logic [spgm_pkg::NUM_SOURCES-1:0]   stereo_mask_reg;
    logic                               cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < spgm_pkg::NUM_SOURCES; s++)
                gain_pan_reg[s] <= spgm_pkg::GAIN_PAN_RESET;
            master_gain_reg <= spgm_pkg::MASTER_GAIN_RESET;
            stereo_mask_reg <= spgm_pkg::STEREO_MASK_RESET;
        end
        else if (cfg_write)
        begin
            // Source registers occupy the indexes below the master gain
            if (cfg_index < spgm_pkg::CFG_MASTER_GAIN)
                gain_pan_reg[cfg_index[spgm_pkg::SRC_IDX_BITS-1:0]] <= cfg_data;
            else if (cfg_index == spgm_pkg::CFG_MASTER_GAIN)
                master_gain_reg <= cfg_data[spgm_pkg::MASTER_BITS-1:0];
            else if (cfg_index == spgm_pkg::CFG_STEREO_MASK)
                stereo_mask_reg <= cfg_data[spgm_pkg::NUM_SOURCES-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input side: the pipeline never blocks, so a frame is taken whenever
    // start is high.
    // ------------------------------------------------------------------
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Unpack the frame word into per-source sample vectors
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] src_left  [spgm_pkg::NUM_SOURCES];
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] src_right [spgm_pkg::NUM_SOURCES];

    always_comb
    begin
        src_left[0]  = frame.src0_left;
        src_right[0] = frame.src0_right;
        src_left[1]  = frame.src1_left;
        src_right[1] = frame.src1_right;
        src_left[2]  = frame.src2_left;
        src_right[2] = frame.src2_right;
        src_left[3]  = frame.src3_left;
        src_right[3] = frame.src3_right;
    end

    // ------------------------------------------------------------------
    // Source lanes: one per source, all working on the same frame
    // ------------------------------------------------------------------
    logic signed [spgm_pkg::PROD_BITS-1:0] prod_l [spgm_pkg::NUM_SOURCES];
    logic signed [spgm_pkg::PROD_BITS-1:0] prod_r [spgm_pkg::NUM_SOURCES];

    for (genvar s = 0; s < spgm_pkg::NUM_SOURCES; s++)
    begin : g_lane
        spgm_pkg::lane_ctl_t ctl;

        assign ctl.stereo  = stereo_mask_reg[s];
        assign ctl.present = frame.present_mask[s];

        spgm_lane #(
            .PAN_TABLE_DEPTH(PAN_TABLE_DEPTH)
        ) u_lane (
            .clk      (clk),
            .left     (src_left[s]),
            .right    (src_right[s]),
            .gain_pan (gain_pan_reg[s]),
            .ctl      (ctl),
            .prod_l   (prod_l[s]),
            .prod_r   (prod_r[s])
        );
    end

    // ------------------------------------------------------------------
    // Merge: sum lanes, master gain, round and saturate
    // ------------------------------------------------------------------
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] mix_left;
    logic signed [spgm_pkg::SAMPLE_BITS-1:0] mix_right;
    logic                                    clipped;

    spgm_merge u_merge (
        .clk         (clk),
        .prod_l      (prod_l),
        .prod_r      (prod_r),
        .master_gain (master_gain_reg),
        .mix_left    (mix_left),
        .mix_right   (mix_right),
        .clipped     (clipped)
    );

    // ------------------------------------------------------------------
    // Word tracking: advance a valid bit and the underrun mask alongside
    // the datapath so done lines up with the merge output register.
    // ------------------------------------------------------------------
    logic [LATENCY-1:0]               valid_pipe_reg;
    logic [spgm_pkg::NUM_SOURCES-1:0] underrun_pipe_reg [LATENCY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else
            valid_pipe_reg <= {valid_pipe_reg[LATENCY-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        underrun_pipe_reg[0] <= ~frame.present_mask;
        for (int i = 1; i < LATENCY; i++)
            underrun_pipe_reg[i] <= underrun_pipe_reg[i-1];
    end

    assign done                 = valid_pipe_reg[LATENCY-1];
    assign result.mix_left      = mix_left;
    assign result.mix_right     = mix_right;
    assign result.clipped       = clipped;
    assign result.underrun_mask = underrun_pipe_reg[LATENCY-1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    localparam logic signed [spgm_pkg::SAMPLE_BITS-1:0] OUT_MAX =
        spgm_pkg::SAMPLE_BITS'((1 << (spgm_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [spgm_pkg::SAMPLE_BITS-1:0] OUT_MIN =
        spgm_pkg::SAMPLE_BITS'(1 << (spgm_pkg::SAMPLE_BITS - 1));

    // Every accepted frame raises done when it leaves the merge output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted frame did not produce a result word on time");

    // The underrun mask on a done word belongs to the frame that word came from
    a_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.underrun_mask == ~$past(frame.present_mask, LATENCY))
        else $error("underrun mask does not match its frame");

    // A clipped word has at least one output pinned to a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.clipped) |->
            (result.mix_left == OUT_MAX || result.mix_left == OUT_MIN ||
             result.mix_right == OUT_MAX || result.mix_right == OUT_MIN))
        else $error("clip flag set without a saturated output");

endmodule
